[rtl/core/ncle_pkg.sv]
// shared types, codes and lookup tables for the noise channel block
// no dependencies; used by ncle_core and noise_channel_lfsr_envelope
package ncle_pkg;

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_TIMER   = 2'd1,
        OP_QUARTER = 2'd2,
        OP_HALF    = 2'd3
    } t_op;

    localparam logic [1:0] REG_CTRL   = 2'd0;
    localparam logic [1:0] REG_SPARE  = 2'd1;
    localparam logic [1:0] REG_PERIOD = 2'd2;
    localparam logic [1:0] REG_LENGTH = 2'd3;

    localparam int unsigned TIMER_W  = 12;
    localparam int unsigned LENGTH_W = 8;
    localparam int unsigned LFSR_W   = 15;
    localparam logic [3:0] LEVEL_MAX = 4'd15;

    typedef struct packed {
        t_op        op;
        logic [1:0] reg_addr;
        logic [7:0] write_data;
    } t_item;

    function automatic logic [TIMER_W-1:0] noise_period(input logic [3:0] sel);
        logic [TIMER_W-1:0] val;
        begin
            case (sel)
                4'd0:    val = 12'd4;
                4'd1:    val = 12'd8;
                4'd2:    val = 12'd16;
                4'd3:    val = 12'd32;
                4'd4:    val = 12'd64;
                4'd5:    val = 12'd96;
                4'd6:    val = 12'd128;
                4'd7:    val = 12'd160;
                4'd8:    val = 12'd202;
                4'd9:    val = 12'd254;
                4'd10:   val = 12'd380;
                4'd11:   val = 12'd508;
                4'd12:   val = 12'd762;
                4'd13:   val = 12'd1016;
                4'd14:   val = 12'd2034;
                default: val = 12'd4068;
            endcase
            return val;
        end
    endfunction

    function automatic logic [LENGTH_W-1:0] length_value(input logic [4:0] sel);
        logic [LENGTH_W-1:0] val;
        begin
            case (sel)
                5'd0:    val = 8'd10;
                5'd1:    val = 8'd254;
                5'd2:    val = 8'd20;
                5'd3:    val = 8'd2;
                5'd4:    val = 8'd40;
                5'd5:    val = 8'd4;
                5'd6:    val = 8'd80;
                5'd7:    val = 8'd6;
                5'd8:    val = 8'd160;
                5'd9:    val = 8'd8;
                5'd10:   val = 8'd60;
                5'd11:   val = 8'd10;
                5'd12:   val = 8'd14;
                5'd13:   val = 8'd12;
                5'd14:   val = 8'd26;
                5'd15:   val = 8'd14;
                5'd16:   val = 8'd12;
                5'd17:   val = 8'd16;
                5'd18:   val = 8'd24;
                5'd19:   val = 8'd18;
                5'd20:   val = 8'd48;
                5'd21:   val = 8'd20;
                5'd22:   val = 8'd96;
                5'd23:   val = 8'd22;
                5'd24:   val = 8'd192;
                5'd25:   val = 8'd24;
                5'd26:   val = 8'd72;
                5'd27:   val = 8'd26;
                5'd28:   val = 8'd16;
                5'd29:   val = 8'd28;
                5'd30:   val = 8'd32;
                default: val = 8'd30;
            endcase
            return val;
        end
    endfunction

endpackage

[rtl/core/ncle_core.sv]
// channel state: registers, period timer, shift register, envelope, length counter
// computes the level that follows each request; uses ncle_pkg
module ncle_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  ncle_pkg::t_item      i_item,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_data,
    output logic [3:0]           o_sample
);

    logic                              r_enabled, n_enabled;
    logic                              r_loop, n_loop;
    logic                              r_const_vol, n_const_vol;
    logic [3:0]                        r_vol, n_vol;
    logic                              r_short, n_short;
    logic [ncle_pkg::TIMER_W-1:0]      r_reload, n_reload;
    logic [ncle_pkg::TIMER_W-1:0]      r_timer, n_timer;
    logic [ncle_pkg::LFSR_W-1:0]       r_lfsr, n_lfsr;
    logic [ncle_pkg::LENGTH_W-1:0]     r_length, n_length;
    logic                              r_env_start, n_env_start;
    logic [3:0]                        r_env_level, n_env_level;
    logic [3:0]                        r_env_div, n_env_div;
    logic                              w_fb;

    assign w_fb = r_lfsr[0] ^ (r_short ? r_lfsr[6] : r_lfsr[1]);

    always_comb begin
        n_enabled   = r_enabled;
        n_loop      = r_loop;
        n_const_vol = r_const_vol;
        n_vol       = r_vol;
        n_short     = r_short;
        n_reload    = r_reload;
        n_timer     = r_timer;
        n_lfsr      = r_lfsr;
        n_length    = r_length;
        n_env_start = r_env_start;
        n_env_level = r_env_level;
        n_env_div   = r_env_div;
        if (i_step) begin
            case (i_item.op)
                ncle_pkg::OP_WRITE: begin
                    case (i_item.reg_addr)
                        ncle_pkg::REG_CTRL: begin
                            n_loop      = i_item.write_data[5];
                            n_const_vol = i_item.write_data[4];
                            n_vol       = i_item.write_data[3:0];
                        end
                        ncle_pkg::REG_PERIOD: begin
                            n_short  = i_item.write_data[7];
                            n_reload = ncle_pkg::noise_period(i_item.write_data[3:0]);
                        end
                        ncle_pkg::REG_LENGTH: begin
                            if (r_enabled) begin
                                n_length = ncle_pkg::length_value(i_item.write_data[7:3]);
                            end
                            n_env_start = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
                ncle_pkg::OP_TIMER: begin
                    if (r_timer != '0) begin
                        n_timer = r_timer - 1'b1;
                    end else begin
                        n_timer = r_reload;
                        n_lfsr  = {w_fb, r_lfsr[ncle_pkg::LFSR_W-1:1]};
                    end
                end
                ncle_pkg::OP_QUARTER: begin
                    if (r_env_start) begin
                        n_env_start = 1'b0;
                        n_env_level = ncle_pkg::LEVEL_MAX;
                        n_env_div   = r_vol;
                    end else if (r_env_div != '0) begin
                        n_env_div = r_env_div - 1'b1;
                    end else begin
                        n_env_div = r_vol;
                        if (r_env_level != '0) begin
                            n_env_level = r_env_level - 1'b1;
                        end else if (r_loop) begin
                            n_env_level = ncle_pkg::LEVEL_MAX;
                        end
                    end
                end
                ncle_pkg::OP_HALF: begin
                    if (!r_loop && r_length != '0) begin
                        n_length = r_length - 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
        // status register write: disabling the channel drops the length count
        if (i_cfg_we) begin
            n_enabled = i_cfg_data;
            if (!i_cfg_data) begin
                n_length = '0;
            end
        end
    end

    // level seen after the request takes effect
    always_comb begin
        if (!n_enabled || n_length == '0 || n_lfsr[0]) begin
            o_sample = 4'd0;
        end else begin
            o_sample = n_const_vol ? n_vol : n_env_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled   <= 1'b0;
            r_loop      <= 1'b0;
            r_const_vol <= 1'b0;
            r_vol       <= '0;
            r_short     <= 1'b0;
            r_reload    <= '0;
            r_timer     <= '0;
            r_lfsr      <= {{(ncle_pkg::LFSR_W-1){1'b0}}, 1'b1};
            r_length    <= '0;
            r_env_start <= 1'b0;
            r_env_level <= '0;
            r_env_div   <= '0;
        end else begin
            r_enabled   <= n_enabled;
            r_loop      <= n_loop;
            r_const_vol <= n_const_vol;
            r_vol       <= n_vol;
            r_short     <= n_short;
            r_reload    <= n_reload;
            r_timer     <= n_timer;
            r_lfsr      <= n_lfsr;
            r_length    <= n_length;
            r_env_start <= n_env_start;
            r_env_level <= n_env_level;
            r_env_div   <= n_env_div;
        end
    end

    // shift register is an invertible map, so it never falls into all zeros
    a_lfsr_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lfsr != '0)
        else $error("noise shift register reached zero");

    a_length_needs_enable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_length != '0 |-> r_enabled)
        else $error("length count held while channel disabled");

    a_disable_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we && !i_cfg_data |=> r_length == '0)
        else $error("length count survived channel disable");

endmodule

[rtl/core/noise_channel_lfsr_envelope.sv]
// top level of the noise channel: input register, channel state, result register
// uses ncle_pkg and ncle_core
//
// Noise voice of a sound chip. Each request is a channel register write, a timer tick,
// a quarter-frame tick or a half-frame tick, and each one returns the channel level
// (0..15) as it stands after that request. A request is taken every cycle while results
// are taken: it waits in the input register, the channel state is updated by
// combinational logic, and the level lands in the result register. While the result
// register is full and not taken, the input register still takes one more request.
// The enable bit is written through i_cfg_we / i_cfg_data; clearing it also zeroes the
// length counter.
module noise_channel_lfsr_envelope (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_op,
    input  logic [1:0] i_reg_addr,
    input  logic [7:0] i_write_data,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [3:0] o_sample,
    input  logic       i_cfg_we,
    input  logic       i_cfg_data
);

    logic              r_in_valid;
    ncle_pkg::t_item   r_item;
    logic              r_out_valid;
    logic [3:0]        r_sample;
    logic              w_advance;
    logic [3:0]        w_next_sample;

    assign w_advance   = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_advance;
    assign o_out_valid = r_out_valid;
    assign o_sample    = r_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item.op         <= ncle_pkg::t_op'(i_op);
            r_item.reg_addr   <= i_reg_addr;
            r_item.write_data <= i_write_data;
        end
    end

    ncle_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (w_advance),
        .i_item     (r_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_sample   (w_next_sample)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_sample <= w_next_sample;
        end
    end

    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_in_valid)
        else $error("input stalled with empty input register");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> r_in_valid)
        else $error("accepted request lost from input register");

    a_advance_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> o_out_valid)
        else $error("processed request produced no result");

endmodule
